FILE: rtl/psd_pkg.sv
package psd_pkg;

    localparam int unsigned NumSlotsDef = 8;
    localparam int unsigned AddrCapDef  = 16;
    localparam int unsigned HashCapDef  = 16;
    localparam logic [15:0] BurstLockReset = 16'd500;

    typedef enum logic [2:0] {
        REQ_ADD_ADDR  = 3'd0,
        REQ_ADD_HASH  = 3'd1,
        REQ_FIND      = 3'd2,
        REQ_CLR_SLOT  = 3'd3,
        REQ_CLR_ALL   = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_INVALID  = 3'd2,
        ST_FULL     = 3'd3,
        ST_LOCKED   = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // command given to each cell of the chain along with the probe word
    typedef struct packed {
        logic       scan;     // compare this cycle
        logic       clr;      // wipe this cell
    } t_cell_ctl;

endpackage

FILE: rtl/psd_cell.sv
// One storage cell: holds one entry of one slot's set in one lane position.
// A cell holds the entry for one (slot, position) pair; compares it with
// the probe word and writes or clears on command.
module psd_cell #(
    parameter int unsigned W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psd_pkg::t_cell_ctl   i_ctl,
    input  logic                 i_wr,
    input  logic [W-1:0]         i_probe,
    input  logic                 i_hit_in,
    output logic                 o_hit
);
    import psd_pkg::*;

    logic [W-1:0] r_val;
    logic [W-1:0] n_val;

    // write, wipe or hold the entry
    always_comb begin
        n_val = r_val;
        if (i_ctl.clr) begin
            n_val = '0;
        end else if (i_wr) begin
            n_val = i_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

    // pass the hit along the chain
    assign o_hit = i_hit_in | (i_ctl.scan && (r_val == i_probe));

endmodule

FILE: rtl/psd_set.sv
// One set kind over all slots: a chain of cells, one per (slot, position).
// Count per slot; scan compares one slot's row (or every row on a find)
// and reports per-slot hits and the fill state of the selected slot.
module psd_set #(
    parameter int unsigned NUM_SLOTS = psd_pkg::NumSlotsDef,
    parameter int unsigned CAP       = psd_pkg::HashCapDef,
    parameter int unsigned W         = 32,
    parameter int unsigned SW        = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [W-1:0]          i_probe,
    input  logic [NUM_SLOTS-1:0]  i_scan_row,
    input  logic [NUM_SLOTS-1:0]  i_clr_row,
    input  logic                  i_append,
    input  logic [SW-1:0]         i_slot,
    output logic [NUM_SLOTS-1:0]  o_hit,
    output logic                  o_full
);
    import psd_pkg::*;

    localparam int unsigned CW = $clog2(CAP + 1);

    logic [CW-1:0] r_cnt [NUM_SLOTS];
    logic [CW-1:0] sel_cnt;

    assign sel_cnt = r_cnt[i_slot[$clog2(NUM_SLOTS > 1 ? NUM_SLOTS : 2)-1:0]];
    assign o_full  = (sel_cnt >= CW'(CAP));

    genvar gs, gp;
    generate
        for (gs = 0; gs < NUM_SLOTS; gs++) begin : g_slot
            logic [CAP:0] hit_chain;
            assign hit_chain[0] = 1'b0;
            for (gp = 0; gp < CAP; gp++) begin : g_pos
                t_cell_ctl ctl;
                logic      wr;
                assign ctl.scan = i_scan_row[gs] && (CW'(gp) < r_cnt[gs]);
                assign ctl.clr  = i_clr_row[gs];
                assign wr = i_append && (i_slot == SW'(gs)) && (r_cnt[gs] == CW'(gp));
                psd_cell #(.W(W)) u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (ctl),
                    .i_wr     (wr),
                    .i_probe  (i_probe),
                    .i_hit_in (hit_chain[gp]),
                    .o_hit    (hit_chain[gp+1])
                );
            end
            assign o_hit[gs] = hit_chain[CAP];

            // count update
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt[gs] <= '0;
                end else if (i_clr_row[gs]) begin
                    r_cnt[gs] <= '0;
                end else if (i_append && (i_slot == SW'(gs)) && (r_cnt[gs] < CW'(CAP))) begin
                    r_cnt[gs] <= r_cnt[gs] + 1'b1;
                end
            end
        end
    endgenerate

`ifndef SYNTHESIS
    a_no_clr_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_append |-> !(|i_clr_row)) else $error("append during clear");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CW'(CAP)) else $error("count overflow");
    a_full_no_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_append && o_full) |=> (r_cnt[0] <= CW'(CAP))) else $error("append when full");
`endif

endmodule

FILE: rtl/per_slot_dedup_set_table.sv
// Per-slot dedup set table.
// Request channel (i_req_valid/o_req_ready) carries one request: add an
// address, add a hash, find the lowest slot holding a hash, clear one slot
// or clear all. Response channel (o_rsp_valid/i_rsp_ready) returns one
// result per request: accepted, status code and found slot.
// Config channel (i_cfg_valid/o_cfg_ready) writes burst_lock_ms; always ready.
// Storage is a chain of cells per set kind; each scanned slot row compares its
// entries in parallel and the hit ripples along the row.
// Flow: the request is captured on accept, compared and committed in the
// scan state, then the result is held until taken. One request at a time:
// next request is taken the cycle after the response has been accepted, so
// a new request cannot start before the last response is taken.
// Reset: all sets empty, counts and last-add times zero, lock 500 ms.
// A stalled receiver holds the response and blocks new requests.
module per_slot_dedup_set_table
    import psd_pkg::*;
#(
    parameter int unsigned NUM_SLOTS        = psd_pkg::NumSlotsDef,
    parameter int unsigned ADDRESS_CAPACITY = psd_pkg::AddrCapDef,
    parameter int unsigned HASH_CAPACITY    = psd_pkg::HashCapDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_slot_index,
    input  logic [47:0] i_instance_address,
    input  logic [31:0] i_hash_value,
    input  logic [31:0] i_time_now_ms,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic        o_accepted,
    output logic [2:0]  o_status_code,
    output logic [3:0]  o_found_slot,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_state      r_state, n_state;
    logic [2:0]  r_req;
    logic [3:0]  r_slot;
    logic [47:0] r_addr;
    logic [31:0] r_hash;
    logic [31:0] r_now;
    logic [15:0] r_lock;
    logic [31:0] r_last [NUM_SLOTS];
    logic        r_acc;
    logic [2:0]  r_st;
    logic [3:0]  r_found;

    logic [NUM_SLOTS-1:0] a_hit, h_hit;
    logic                 a_full, h_full;
    logic [NUM_SLOTS-1:0] a_scan, h_scan, clr_row;
    logic                 a_app, h_app;
    logic                 slot_ok;
    logic [2:0]           st;
    logic [3:0]           found;
    logic [31:0]          last_sel, elapsed;

    assign o_cfg_ready = 1'b1;
    assign slot_ok = ({28'd0, r_slot} < 32'(NUM_SLOTS));

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock <= BurstLockReset;
        end else if (i_cfg_valid) begin
            r_lock <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_SCAN;
            S_SCAN: n_state = S_DONE;
            S_DONE: if (i_rsp_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs of the sequencer
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_rsp_valid = (r_state == S_DONE);
    end

    // capture request
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req  <= i_req_type;
            r_slot <= i_slot_index;
            r_addr <= i_instance_address;
            r_hash <= i_hash_value;
            r_now  <= i_time_now_ms;
        end
    end

    assign last_sel = r_last[r_slot[SIW-1:0]];
    assign elapsed  = r_now - last_sel;

    // decide status during the compare cycle
    always_comb begin
        st      = ST_INVALID;
        found   = '0;
        a_app   = 1'b0;
        h_app   = 1'b0;
        clr_row = '0;
        a_scan  = '0;
        h_scan  = '0;
        if (slot_ok) begin
            a_scan[r_slot[SIW-1:0]] = (r_req == REQ_ADD_ADDR);
            h_scan[r_slot[SIW-1:0]] = (r_req == REQ_ADD_HASH);
        end
        if (r_req == REQ_FIND) h_scan = '1;
        if (r_state == S_SCAN) begin
            unique case (r_req)
                REQ_ADD_ADDR: begin
                    if (r_addr != '0 && slot_ok) begin
                        if (|a_hit)       st = ST_PRESENT;
                        else if (a_full)  st = ST_FULL;
                        else begin
                            st = ST_OK;
                            a_app = 1'b1;
                        end
                    end
                end
                REQ_ADD_HASH: begin
                    if (r_hash != '0 && slot_ok) begin
                        if (|h_hit) st = ST_PRESENT;
                        else if (last_sel != '0 && elapsed > {16'd0, r_lock}) st = ST_LOCKED;
                        else if (h_full) st = ST_FULL;
                        else begin
                            st = ST_OK;
                            h_app = 1'b1;
                        end
                    end
                end
                REQ_FIND: begin
                    st = ST_NOTFOUND;
                    if (r_hash != '0) begin
                        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
                            if (h_hit[s]) begin
                                st = ST_OK;
                                found = 4'(s);
                            end
                        end
                    end
                end
                REQ_CLR_SLOT: begin
                    if (slot_ok) begin
                        st = ST_OK;
                        clr_row[r_slot[SIW-1:0]] = 1'b1;
                    end
                end
                REQ_CLR_ALL: begin
                    st = ST_OK;
                    clr_row = '1;
                end
                default: st = ST_INVALID;
            endcase
        end
    end

    // last-add times
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!i_rst_n || clr_row[s]) begin
                r_last[s] <= '0;
            end else if (h_app && r_slot[SIW-1:0] == SIW'(s)) begin
                r_last[s] <= r_now;
            end
        end
    end

    // hold result
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_st    <= st;
            r_acc   <= (st == ST_OK) || (st == ST_PRESENT);
            r_found <= found;
        end
    end

    assign o_accepted    = r_acc;
    assign o_status_code = r_st;
    assign o_found_slot  = r_found;

    psd_set #(.NUM_SLOTS(NUM_SLOTS), .CAP(ADDRESS_CAPACITY), .W(48), .SW(4)) u_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_probe    (r_addr),
        .i_scan_row (a_scan),
        .i_clr_row  (clr_row),
        .i_append   (a_app),
        .i_slot     (r_slot),
        .o_hit      (a_hit),
        .o_full     (a_full)
    );

    psd_set #(.NUM_SLOTS(NUM_SLOTS), .CAP(HASH_CAPACITY), .W(32), .SW(4)) u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_probe    (r_hash),
        .i_scan_row (h_scan),
        .i_clr_row  (clr_row),
        .i_append   (h_app),
        .i_slot     (r_slot),
        .o_hit      (h_hit),
        .o_full     (h_full)
    );

`ifndef SYNTHESIS
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req_ready && i_req_valid) |=> !o_req_ready) else $error("second request taken");
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req_ready && i_req_valid) |-> ##2 o_rsp_valid) else $error("response late");
    a_acc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_accepted == (o_status_code == ST_OK || o_status_code == ST_PRESENT)))
        else $error("accepted flag mismatch");
`endif

endmodule

FILE: tb/sv/per_slot_dedup_set_table_tb.sv
module per_slot_dedup_set_table_tb;
    import psd_pkg::*;

    localparam int NSLOT = 8;
    localparam int ACAP = 16;
    localparam int HCAP = 16;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       acc;
        logic [2:0] status;
        logic [3:0] slot;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    logic [2:0]  i_req_type = '0;
    logic [3:0]  i_slot_index = '0;
    logic [47:0] i_instance_address = '0;
    logic [31:0] i_hash_value = '0;
    logic [31:0] i_time_now_ms = '0;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    logic        o_accepted;
    logic [2:0]  o_status_code;
    logic [3:0]  o_found_slot;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    per_slot_dedup_set_table DUT (
        .i_clk, .i_rst_n, .i_req_valid, .o_req_ready, .i_req_type, .i_slot_index,
        .i_instance_address, .i_hash_value, .i_time_now_ms, .o_rsp_valid,
        .i_rsp_ready, .o_accepted, .o_status_code, .o_found_slot,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    // shadow copy of the table
    logic [47:0] addr_tab [NSLOT][ACAP];
    int          addr_cnt [NSLOT];
    logic [31:0] hash_tab [NSLOT][HCAP];
    int          hash_cnt [NSLOT];
    logic [31:0] last_add [NSLOT];
    logic [15:0] lock_ms;

    t_outcome    expected_q[$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [31:0] clock_ms = 32'd1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // randomly stall the receiver
    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each response with the oldest prediction
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected response");
                fail_count++;
            end else begin
                exp_o = expected_q.pop_front();
                if (o_accepted !== exp_o.acc) begin
                    $error("accepted exp %0d got %0d", exp_o.acc, o_accepted);
                    fail_count++;
                end
                if (o_status_code !== exp_o.status) begin
                    $error("status_code exp %0d got %0d", exp_o.status, o_status_code);
                    fail_count++;
                end
                if (o_found_slot !== exp_o.slot) begin
                    $error("found_slot exp %0d got %0d", exp_o.slot, o_found_slot);
                    fail_count++;
                end
            end
        end
    end

    function automatic void wipe_slot(int s);
        for (int i = 0; i < ACAP; i++) addr_tab[s][i] = '0;
        for (int i = 0; i < HCAP; i++) hash_tab[s][i] = '0;
        addr_cnt[s] = 0;
        hash_cnt[s] = 0;
        last_add[s] = '0;
    endfunction

    function automatic t_outcome apply_request(logic [2:0] rt, logic [3:0] si,
                                               logic [47:0] ad, logic [31:0] hv,
                                               logic [31:0] now);
        t_outcome    res;
        t_status     st;
        logic        hit;
        logic [31:0] elapsed;
        st = ST_INVALID;
        res.slot = '0;
        hit = 1'b0;
        case (rt)
            REQ_ADD_ADDR: begin
                if (ad != 0 && si < NSLOT) begin
                    for (int i = 0; i < addr_cnt[si]; i++)
                        if (addr_tab[si][i] == ad) hit = 1'b1;
                    if (hit) st = ST_PRESENT;
                    else if (addr_cnt[si] >= ACAP) st = ST_FULL;
                    else begin
                        addr_tab[si][addr_cnt[si]] = ad;
                        addr_cnt[si]++;
                        st = ST_OK;
                    end
                end
            end
            REQ_ADD_HASH: begin
                if (hv != 0 && si < NSLOT) begin
                    elapsed = now - last_add[si];
                    for (int i = 0; i < hash_cnt[si]; i++)
                        if (hash_tab[si][i] == hv) hit = 1'b1;
                    if (hit) st = ST_PRESENT;
                    else if (last_add[si] != 0 && elapsed > {16'd0, lock_ms}) st = ST_LOCKED;
                    else if (hash_cnt[si] >= HCAP) st = ST_FULL;
                    else begin
                        hash_tab[si][hash_cnt[si]] = hv;
                        hash_cnt[si]++;
                        last_add[si] = now;
                        st = ST_OK;
                    end
                end
            end
            REQ_FIND: begin
                st = ST_NOTFOUND;
                if (hv != 0) begin
                    for (int s = NSLOT - 1; s >= 0; s--)
                        for (int i = 0; i < hash_cnt[s]; i++)
                            if (hash_tab[s][i] == hv) begin
                                st = ST_OK;
                                res.slot = 4'(s);
                            end
                end
            end
            REQ_CLR_SLOT: begin
                if (si < NSLOT) begin
                    wipe_slot(si);
                    st = ST_OK;
                end
            end
            REQ_CLR_ALL: begin
                for (int s = 0; s < NSLOT; s++) wipe_slot(s);
                st = ST_OK;
            end
            default: st = ST_INVALID;
        endcase
        res.status = st;
        res.acc = (st == ST_OK || st == ST_PRESENT);
        return res;
    endfunction

    // send one request and record its prediction when accepted
    task automatic send_request(logic [2:0] rt, logic [3:0] si, logic [47:0] ad,
                                logic [31:0] hv, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req_type <= rt;
        i_slot_index <= si;
        i_instance_address <= ad;
        i_hash_value <= hv;
        i_time_now_ms <= now;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        expected_q.push_back(apply_request(rt, si, ad, hv, now));
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_lock(logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        lock_ms = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(REQ_ADD_ADDR, 4'd0, 48'd0, 32'd0, 32'd0);
        send_request(REQ_ADD_ADDR, 4'd0, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0);
        send_request(REQ_ADD_ADDR, 4'd0, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0);
        send_request(REQ_ADD_ADDR, 4'd8, 48'd5, 32'd0, 32'd0);
        send_request(REQ_ADD_ADDR, 4'd15, 48'd5, 32'd0, 32'd0);
        send_request(REQ_ADD_HASH, 4'd7, 48'd0, 32'd0, 32'd10);
        send_request(REQ_ADD_HASH, 4'd7, 48'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_ADD_HASH, 4'd7, 48'd0, 32'd3, 32'd0);
        send_request(REQ_ADD_HASH, 4'd3, 48'd0, 32'd9, 32'hFFFF_FFF0);
        send_request(REQ_ADD_HASH, 4'd3, 48'd0, 32'd10, 32'h0000_0100);
        send_request(REQ_ADD_HASH, 4'd2, 48'd0, 32'd9, 32'd1);
        send_request(REQ_ADD_HASH, 4'd3, 48'd0, 32'h8000_0000, 32'd5000);
        send_request(REQ_FIND, 4'd15, 48'd0, 32'd9, 32'd0);
        send_request(REQ_FIND, 4'd0, 48'd0, 32'd0, 32'd0);
        send_request(REQ_FIND, 4'd0, 48'd0, 32'd77, 32'd0);
        send_request(REQ_CLR_SLOT, 4'd9, 48'd0, 32'd0, 32'd0);
        send_request(REQ_CLR_SLOT, 4'd2, 48'd0, 32'd0, 32'd0);
        send_request(3'd5, 4'd0, 48'd1, 32'd1, 32'd1);
        send_request(3'd7, 4'd0, 48'd1, 32'd1, 32'd1);
        // fill one address set past capacity
        for (int i = 1; i <= ACAP + 1; i++)
            send_request(REQ_ADD_ADDR, 4'd5, 48'(i), 32'd0, 32'd0);
        send_request(REQ_CLR_ALL, 4'd0, 48'd0, 32'd0, 32'd0);
    endtask

    // mostly adds to few slots with small value pools so hits and fills occur
    task automatic test_random(int n_items);
        logic [2:0]  rt;
        logic [47:0] ad;
        logic [31:0] hv;
        int          pick;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 38) rt = REQ_ADD_ADDR;
            else if (pick < 76) rt = REQ_ADD_HASH;
            else if (pick < 90) rt = REQ_FIND;
            else if (pick < 96) rt = REQ_CLR_SLOT;
            else if (pick < 98) rt = REQ_CLR_ALL;
            else rt = 3'($urandom_range(7));
            ad = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                          : 48'($urandom_range(24));
            hv = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(24));
            case ($urandom_range(3))
                0: clock_ms = $urandom;
                1: clock_ms = clock_ms + {16'd0, lock_ms} + 32'($urandom_range(2));
                default: clock_ms = clock_ms + 32'($urandom_range(300));
            endcase
            send_request(rt, ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(3)),
                         ad, hv, clock_ms);
        end
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++) wipe_slot(s);
        lock_ms = BurstLockReset;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 46;
        test_directed();
        write_lock(16'd0);
        test_random(250);
        write_lock(16'hFFFF);
        test_random(250);

        send_idle_pct = 46;
        recv_idle_pct = 23;
        write_lock(16'd100);
        test_random(350);
        drain();
        write_lock(16'd1);
        test_random(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_lock(16'd500);
        test_random(500);
        drain();

        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
